// File: sv/pthr_pkg.sv
// ----------------------------------------------------------------------------
// pthr_pkg: shared types and constants of the pad to HID axis report unit
// Word layouts of both channels, pad kind codes, register indexes and the
// fixed constants of the axis scaling.
// ----------------------------------------------------------------------------
`default_nettype none

package pthr_pkg;

  // Pad kind codes carried in the command field.
  localparam logic [1:0] PAD_NONE = 2'd0;
  localparam logic [1:0] PAD_N64  = 2'd1;
  localparam logic [1:0] PAD_GC   = 2'd2;

  // Configuration register indexes (byte address is four times the index).
  localparam int unsigned CFG_AW = 4;
  localparam logic [1:0] CFG_IDX_SLIDERS = 2'd0;
  localparam logic [1:0] CFG_IDX_FULL    = 2'd1;
  localparam logic [1:0] CFG_IDX_INVERT  = 2'd2;

  // Button bits that the analog triggers set when they act as buttons.
  localparam int unsigned LEFT_BUTTON_BIT  = 6;
  localparam int unsigned RIGHT_BUTTON_BIT = 5;

  localparam logic [15:0] AXIS_CENTRE = 16'd16000;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [7:0]  stick_x;
    logic signed [7:0]  stick_y;
    logic signed [7:0]  cstick_x;
    logic signed [7:0]  cstick_y;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
    logic [15:0]        button_bits;
  } pad_word_t;

  typedef struct packed {
    logic [15:0] axis_x_word;
    logic [15:0] axis_y_word;
    logic [15:0] caxis_x_word;
    logic [15:0] caxis_y_word;
    logic [15:0] ltrig_word;
    logic [15:0] rtrig_word;
    logic [15:0] report_buttons;
  } report_word_t;

endpackage

`default_nettype wire

// File: sv/pad_to_hid_axis_report_unit.sv
// ----------------------------------------------------------------------------
// pad_to_hid_axis_report_unit: controller sample to HID axis report
// Turns one tagged N64 or GameCube pad sample into six axis words and a
// button word, with trigger handling set by three configuration bits.
// ----------------------------------------------------------------------------
// Usage:
// A pad sample arrives as one word on the in_ channel and is taken at a clock
// edge where in_valid is high and in_stall is low. Each sample gives exactly
// one report word on the out_ channel, taken where out_valid is high and
// out_stall is low. The block is a two-register pipeline: the sample is
// captured in an input register, the scaling and clamping run in one short
// combinational pass, and the report is held in an output register. out_valid
// rises once the sample has moved from the input register into the output
// register. One sample can be accepted in every cycle while the receiver
// does not stall, so the sustained rate is then one word per clock.
// When the receiver stalls, the output register holds its word and the input
// register can still take one more sample; in_stall rises only when both are
// full and the output is stalled.
// The user must write the three trigger mode bits over the cfg_ port only
// while no word is in flight; the block does not enforce it. Reset (rst_n
// low, synchronous) empties the pipeline and clears all three mode bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pad_to_hid_axis_report_unit (
  input  wire                         clk,
  input  wire                         rst_n,
  // Pad sample channel.
  input  wire                         in_valid,
  output logic                        in_stall,
  input  pthr_pkg::pad_word_t         in_data,
  // Report channel.
  output logic                        out_valid,
  input  wire                         out_stall,
  output pthr_pkg::report_word_t      out_data,
  // Register port.
  input  wire                         cfg_psel,
  input  wire                         cfg_penable,
  input  wire                         cfg_pwrite,
  input  wire [pthr_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire [31:0]                  cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  import pthr_pkg::*;

  // Mode registers.
  logic sliders_r, full_r, invert_r;
  logic cfg_wr;

  // Pipeline registers.
  logic         s1_valid_r;
  pad_word_t    s1_data_r;
  logic         out_valid_r;
  report_word_t out_data_r;
  report_word_t rep_nxt;

  logic s1_adv;
  logic in_acc;

  // Clamp a signed stick value to +/- lim.
  function automatic logic signed [7:0] clamp_axis(input logic signed [7:0] v,
                                                   input logic signed [7:0] lim);
    logic signed [7:0] r;
    begin
      r = v;
      if (v > lim) r = lim;
      if (v < -lim) r = -lim;
      return r;
    end
  endfunction

  // Offset a signed axis value into an unsigned report word (mod 65536).
  function automatic logic [15:0] to_word(input logic signed [17:0] v);
    logic signed [17:0] s;
    begin
      s = v + $signed({2'b00, AXIS_CENTRE});
      return s[15:0];
    end
  endfunction

  function automatic logic signed [17:0] trig_value(input logic [7:0] t,
                                                    input logic full,
                                                    input logic inv);
    logic signed [9:0]  d;
    logic signed [17:0] v;
    logic [13:0]        p;
    begin
      d = $signed({2'b00, t}) - 10'sd127;
      p = 14'(t) * 14'd63;
      if (full) begin
        v = 18'(d) * 18'sd126;
      end else if (p > 14'd16000) begin
        v = 18'sd16000;
      end else begin
        v = $signed({4'b0000, p});
      end
      if (inv) v = -v;
      return v;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Configuration port. Only paddr[3:2] selects the register, so any write
  // to index three is dropped.
  // --------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sliders_r <= 1'b0;
      full_r    <= 1'b0;
      invert_r  <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        CFG_IDX_SLIDERS: sliders_r <= cfg_pwdata[0];
        CFG_IDX_FULL:    full_r    <= cfg_pwdata[0];
        CFG_IDX_INVERT:  invert_r  <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      CFG_IDX_SLIDERS: cfg_prdata = {31'd0, sliders_r};
      CFG_IDX_FULL:    cfg_prdata = {31'd0, full_r};
      CFG_IDX_INVERT:  cfg_prdata = {31'd0, invert_r};
      default:         cfg_prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake. The input register moves into the output register whenever
  // the output is empty or being taken.
  // --------------------------------------------------------------------------
  assign s1_adv   = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Report computation from the input register.
  // --------------------------------------------------------------------------
  always_comb begin
    logic signed [7:0] sx, sy, cx, cy;
    logic [15:0]       btn;
    rep_nxt.axis_x_word    = AXIS_CENTRE;
    rep_nxt.axis_y_word    = AXIS_CENTRE;
    rep_nxt.caxis_x_word   = AXIS_CENTRE;
    rep_nxt.caxis_y_word   = AXIS_CENTRE;
    rep_nxt.ltrig_word     = AXIS_CENTRE;
    rep_nxt.rtrig_word     = AXIS_CENTRE;
    rep_nxt.report_buttons = 16'd0;
    sx  = 8'sd0;
    sy  = 8'sd0;
    cx  = 8'sd0;
    cy  = 8'sd0;
    btn = s1_data_r.button_bits;
    case (s1_data_r.command)
      PAD_N64: begin
        sx = clamp_axis(s1_data_r.stick_x, 8'sd80);
        sy = clamp_axis(s1_data_r.stick_y, 8'sd80);
        rep_nxt.axis_x_word    = to_word(18'(sx) * 18'sd200);
        rep_nxt.axis_y_word    = to_word(18'(sy) * -18'sd200);
        rep_nxt.report_buttons = btn;
      end
      PAD_GC: begin
        sx = clamp_axis(s1_data_r.stick_x, 8'sd100);
        sy = clamp_axis(s1_data_r.stick_y, 8'sd100);
        cx = clamp_axis(s1_data_r.cstick_x, 8'sd100);
        cy = clamp_axis(s1_data_r.cstick_y, 8'sd100);
        rep_nxt.axis_x_word  = to_word(18'(sx) * 18'sd160);
        rep_nxt.axis_y_word  = to_word(18'(sy) * -18'sd160);
        rep_nxt.caxis_x_word = to_word(18'(cx) * 18'sd160);
        rep_nxt.caxis_y_word = to_word(18'(cy) * -18'sd160);
        if (sliders_r) begin
          // Triggers act as buttons; the trigger words stay centred.
          if (s1_data_r.left_trigger > 8'd32) btn[LEFT_BUTTON_BIT] = 1'b1;
          if (s1_data_r.right_trigger > 8'd32) btn[RIGHT_BUTTON_BIT] = 1'b1;
        end else begin
          rep_nxt.ltrig_word = to_word(trig_value(s1_data_r.left_trigger,
                                                  full_r, invert_r));
          rep_nxt.rtrig_word = to_word(trig_value(s1_data_r.right_trigger,
                                                  full_r, invert_r));
        end
        rep_nxt.report_buttons = btn;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Pipeline registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_adv || !s1_valid_r) begin
        s1_valid_r <= in_acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_data_r <= in_data;
    end
    if (s1_adv && s1_valid_r) begin
      out_data_r <= rep_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled while pipeline has room");

  a_s1_moves_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv) |=> out_valid_r)
    else $error("sample lost between input and output register");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_data_r)))
    else $error("held sample changed while output stalled");

  a_n64_trig_centred: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_adv && s1_data_r.command != PAD_GC) |=>
    (out_data_r.ltrig_word == AXIS_CENTRE && out_data_r.rtrig_word == AXIS_CENTRE))
    else $error("trigger word not centred for non-GameCube sample");

endmodule

`default_nettype wire
